@@ src/sdt_pkg.sv @@
// Shared types and constants for the stream directive tracker.
`timescale 1ns / 1ps

package sdt_pkg;

	localparam int STREAM_SLOTS_DEF = 16;
	localparam int CFG_DATA_W       = 5;
	localparam int CFG_IDX_W        = 1;
	localparam int SID_W            = 16;

	localparam logic [4:0] MAX_STREAMS_RESET = 5'd8;

	// Command codes
	localparam logic [2:0] MODE_WRITE       = 3'd0;
	localparam logic [2:0] MODE_RELEASE_ID  = 3'd1;
	localparam logic [2:0] MODE_ALLOCATE    = 3'd2;
	localparam logic [2:0] MODE_RELEASE_RES = 3'd3;
	localparam logic [2:0] MODE_SET_ENABLE  = 3'd4;

	// Completion status codes
	localparam logic [1:0] ST_SUCCESS        = 2'd0;
	localparam logic [1:0] ST_INVALID_FIELD  = 2'd1;
	localparam logic [1:0] ST_INVALID_OPCODE = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_STREAMS   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIR_SUPPORTED = 1'd1;

	typedef struct packed {
		logic [2:0]       mode;
		logic [SID_W-1:0] stream_id;
		logic [15:0]      request_count;
		logic             enable_bit;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] granted_count;
		logic [4:0]  open_now;
		logic        enabled_now;
	} rsp_item_t;

	typedef struct packed {
		logic [4:0] max_streams;
		logic       dir_supported;
	} sdt_cfg_t;

endpackage

@@ src/sdt_list_mem.sv @@
// Single-write, single-read stream ID list memory with registered read data.
`timescale 1ns / 1ps

module sdt_list_mem #(
	parameter int DEPTH = sdt_pkg::STREAM_SLOTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [sdt_pkg::SID_W-1:0]            wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [sdt_pkg::SID_W-1:0]            rdata
);

	logic [sdt_pkg::SID_W-1:0] mem_q [DEPTH];
	logic [sdt_pkg::SID_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/sdt_seq.sv @@
// Command sequencer: slot-at-a-time search, compaction shift, resource accounting.
`timescale 1ns / 1ps

module sdt_seq #(
	parameter int STREAM_SLOTS = sdt_pkg::STREAM_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  sdt_pkg::cmd_item_t   cmd,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output sdt_pkg::rsp_item_t   rsp,
	input  sdt_pkg::sdt_cfg_t    cfg
);

	localparam int IW   = STREAM_SLOTS > 1 ? $clog2(STREAM_SLOTS) : 1;
	localparam int CW   = $clog2(STREAM_SLOTS + 1);
	localparam int CMPW = CW > 5 ? CW : 5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRD,
		S_SCMP,
		S_INSERT,
		S_SHF,
		S_SWR,
		S_APPEND,
		S_DONE
	} state_t;

	state_t                    state_q;
	logic [IW-1:0]             idx_q;
	logic [CW-1:0]             cnt_q;
	sdt_pkg::cmd_item_t        cmd_q;
	logic                      append_q;
	logic [1:0]                status_q;
	logic [15:0]               granted_q;
	logic [15:0]               alloc_q;
	logic [15:0]               avail_q;
	logic                      enabled_q;
	logic                      rsp_valid_q;
	sdt_pkg::rsp_item_t        rsp_q;

	logic                      accept;
	logic [15:0]               grant;
	logic                      full;
	logic                      last_slot;
	logic                      shift_more;
	logic                      mem_we;
	logic [IW-1:0]             mem_waddr;
	logic [sdt_pkg::SID_W-1:0] mem_wdata;
	logic [IW-1:0]             mem_raddr;
	logic [sdt_pkg::SID_W-1:0] mem_rdata;

	assign cmd_stall = (state_q != S_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign grant     = (cmd.request_count < avail_q) ? cmd.request_count : avail_q;
	assign full      = (CMPW'(cnt_q) >= CMPW'(cfg.max_streams)) ||
	                   (cnt_q >= CW'(STREAM_SLOTS));
	assign last_slot  = (CW'(idx_q) + CW'(1)) == cnt_q;
	// cnt_q is already decremented while compacting
	assign shift_more = CW'(idx_q) < cnt_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = mem_rdata;
		mem_raddr = idx_q;
		unique case (state_q)
			S_SHF: begin
				mem_raddr = idx_q + IW'(1);
			end
			S_SWR: begin
				mem_we = 1'b1;
			end
			S_APPEND: begin
				mem_we    = (cnt_q < CW'(STREAM_SLOTS));
				mem_waddr = cnt_q[IW-1:0];
				mem_wdata = cmd_q.stream_id;
			end
			default: begin
			end
		endcase
	end

	sdt_list_mem #(
		.DEPTH(STREAM_SLOTS)
	) u_list_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			cnt_q       <= '0;
			append_q    <= 1'b0;
			status_q    <= sdt_pkg::ST_SUCCESS;
			granted_q   <= '0;
			alloc_q     <= '0;
			avail_q     <= 16'(sdt_pkg::MAX_STREAMS_RESET);
			enabled_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q    <= cmd;
						idx_q    <= '0;
						append_q <= (cmd.mode == sdt_pkg::MODE_WRITE);
						if (!cfg.dir_supported) begin
							status_q  <= sdt_pkg::ST_INVALID_OPCODE;
							granted_q <= '0;
							state_q   <= S_DONE;
						end else begin
							unique case (cmd.mode)
								sdt_pkg::MODE_WRITE: begin
									status_q  <= sdt_pkg::ST_SUCCESS;
									granted_q <= '0;
									if (cmd.stream_id == '0) begin
										state_q <= S_DONE;
									end else begin
										state_q <= (cnt_q == '0) ? S_INSERT : S_SRD;
									end
								end
								sdt_pkg::MODE_RELEASE_ID: begin
									status_q  <= sdt_pkg::ST_SUCCESS;
									granted_q <= '0;
									state_q   <= (cnt_q != '0) ? S_SRD : S_DONE;
								end
								sdt_pkg::MODE_ALLOCATE: begin
									state_q <= S_DONE;
									if (alloc_q != '0) begin
										status_q  <= sdt_pkg::ST_INVALID_FIELD;
										granted_q <= '0;
									end else begin
										status_q  <= sdt_pkg::ST_SUCCESS;
										granted_q <= grant;
										alloc_q   <= grant;
										avail_q   <= avail_q - grant;
									end
								end
								sdt_pkg::MODE_RELEASE_RES: begin
									status_q  <= sdt_pkg::ST_SUCCESS;
									granted_q <= '0;
									state_q   <= S_DONE;
									alloc_q   <= '0;
									avail_q   <= 16'(cfg.max_streams);
								end
								sdt_pkg::MODE_SET_ENABLE: begin
									status_q  <= sdt_pkg::ST_SUCCESS;
									granted_q <= '0;
									state_q   <= S_DONE;
									enabled_q <= cmd.enable_bit;
								end
								default: begin
									status_q  <= sdt_pkg::ST_INVALID_FIELD;
									granted_q <= '0;
									state_q   <= S_DONE;
								end
							endcase
						end
					end
				end
				S_SRD: begin
					state_q <= S_SCMP;
				end
				S_SCMP: begin
					if (mem_rdata == cmd_q.stream_id) begin
						if (append_q) begin
							state_q <= S_DONE;
						end else begin
							cnt_q   <= cnt_q - CW'(1);
							state_q <= S_SHF;
						end
					end else if (last_slot) begin
						state_q <= append_q ? S_INSERT : S_DONE;
					end else begin
						idx_q   <= idx_q + IW'(1);
						state_q <= S_SRD;
					end
				end
				S_INSERT: begin
					// evict the oldest entry before appending
					if (full && cnt_q != '0) begin
						cnt_q   <= cnt_q - CW'(1);
						idx_q   <= '0;
						state_q <= S_SHF;
					end else begin
						state_q <= S_APPEND;
					end
				end
				S_SHF: begin
					if (shift_more) begin
						state_q <= S_SWR;
					end else begin
						state_q <= append_q ? S_APPEND : S_DONE;
					end
				end
				S_SWR: begin
					idx_q   <= idx_q + IW'(1);
					state_q <= S_SHF;
				end
				S_APPEND: begin
					if (cnt_q < CW'(STREAM_SLOTS)) begin
						cnt_q <= cnt_q + CW'(1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.status        <= status_q;
						rsp_q.granted_count <= granted_q;
						rsp_q.open_now      <= 5'(cnt_q);
						rsp_q.enabled_now   <= enabled_q;
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ src/stream_directive_tracker.sv @@
// Stream directive tracker top level: configuration registers and sequencer.
`timescale 1ns / 1ps

// Tracks the open write streams of one namespace in an ordered list, oldest
// first, plus the allocate/release resource counts and the enable flag. One
// command is handled at a time and cmd_stall stays high until its response is
// formed. The list lives in a single-port-read memory that is visited one slot
// at a time (address, then compare or move), so allocate, release-resources,
// set-enable, unknown and rejected commands do not visit the list; a
// stream-tagged write or a release-id searches the open slots and moves entries
// when the list is compacted, and a write may also evict and append. A finished
// response waits in the output register while the next command is taken.
// Configuration is to be written by the user only while idle; the block itself
// does not enforce it.
module stream_directive_tracker #(
	parameter int STREAM_SLOTS = sdt_pkg::STREAM_SLOTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_stall,
	input  sdt_pkg::cmd_item_t                  cmd,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output sdt_pkg::rsp_item_t                  rsp,
	input  logic                                cfg_we,
	input  logic [sdt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sdt_pkg::CFG_DATA_W-1:0]      cfg_data
);

	sdt_pkg::sdt_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_streams   <= sdt_pkg::MAX_STREAMS_RESET;
			cfg_q.dir_supported <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sdt_pkg::CFG_MAX_STREAMS:   cfg_q.max_streams   <= cfg_data[4:0];
				sdt_pkg::CFG_DIR_SUPPORTED: cfg_q.dir_supported <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	sdt_seq #(
		.STREAM_SLOTS(STREAM_SLOTS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg       (cfg_q)
	);

endmodule

@@ src/sdt_checker.sv @@
// Port-level checks for the stream directive tracker, bound to the top level.
`timescale 1ns / 1ps

module sdt_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cmd_valid,
	input logic                           cmd_stall,
	input logic                           rsp_valid,
	input logic                           rsp_stall,
	input sdt_pkg::rsp_item_t             rsp
);

	// a held response keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// one command in flight: busy right after a transaction
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command taken while previous one in flight");

	// a new response only appears when a command was being worked on
	a_rsp_from_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(cmd_stall))
		else $error("response without a command");

	// grants only come with success
	a_grant_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.granted_count == '0 || rsp.status == sdt_pkg::ST_SUCCESS))
		else $error("nonzero grant on failed command");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == sdt_pkg::ST_SUCCESS ||
		               rsp.status == sdt_pkg::ST_INVALID_FIELD ||
		               rsp.status == sdt_pkg::ST_INVALID_OPCODE))
		else $error("undefined status code");

endmodule

bind stream_directive_tracker sdt_checker u_sdt_checker (.*);

@@ sim/tb_top.sv @@
// Self-checking testbench for the stream directive tracker.
`timescale 1ns / 1ps

module tb_top;

	localparam int          SLOTS        = sdt_pkg::STREAM_SLOTS_DEF;
	localparam int          LIMIT_CYCLES = 500000;
	localparam int          N_PHASES     = 9;
	localparam int          RAND_PER_PH  = 100;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          DRAIN_CYCLES = 80;
	localparam logic [2:0]  MODE_BAD_LO  = 3'd5;
	localparam logic [2:0]  MODE_BAD_HI  = 3'd7;

	typedef struct {
		sdt_pkg::cmd_item_t c;
		bit                 typed;
		sdt_pkg::rsp_item_t exp;
	} dir_row_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          cmd_valid = 1'b0;
	logic                          cmd_stall;
	sdt_pkg::cmd_item_t            cmd       = '0;
	logic                          rsp_valid;
	logic                          rsp_stall = 1'b0;
	sdt_pkg::rsp_item_t            rsp;
	logic                          cfg_we    = 1'b0;
	logic [sdt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [sdt_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	// predicted state of the tracker
	logic [15:0] open_ids [SLOTS];
	int unsigned n_open;
	logic [15:0] ns_grant;
	logic [15:0] sys_free;
	logic        strm_en;
	logic [4:0]  cfg_max;
	logic        cfg_dir_on;

	sdt_pkg::rsp_item_t rsp_q [$];
	dir_row_t           dir_rows [$];
	logic [15:0]        id_pool [24];

	int snd_pct = 0;
	int rcv_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int errors = 0;
	int n_cmd = 0;
	int n_rsp = 0;
	int cycles = 0;

	stream_directive_tracker u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("%0t: timeout, %0d responses still pending", $time, rsp_q.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver: random stall, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left--;
		end else if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rcv_pct);
		end
	end

	always @(posedge clk) begin : rsp_check
		sdt_pkg::rsp_item_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_q.size() == 0) begin
				$display("%0t: response with none expected: %p", $time, rsp);
				errors++;
			end else begin
				e = rsp_q.pop_front();
				n_rsp++;
				if (rsp.status !== e.status) begin
					$display("%0t: status exp %0d got %0d", $time, e.status, rsp.status);
					errors++;
				end
				if (rsp.granted_count !== e.granted_count) begin
					$display("%0t: granted_count exp %0d got %0d", $time,
						e.granted_count, rsp.granted_count);
					errors++;
				end
				if (rsp.open_now !== e.open_now) begin
					$display("%0t: open_now exp %0d got %0d", $time, e.open_now, rsp.open_now);
					errors++;
				end
				if (rsp.enabled_now !== e.enabled_now) begin
					$display("%0t: enabled_now exp %0d got %0d", $time,
						e.enabled_now, rsp.enabled_now);
					errors++;
				end
			end
		end
	end

	function automatic int find_open(logic [15:0] id);
		for (int i = 0; i < n_open && i < SLOTS; i++)
			if (open_ids[i] == id)
				return i;
		return -1;
	endfunction

	function automatic void drop_open(int unsigned pos);
		if (n_open == 0)
			return;
		n_open--;
		for (int unsigned i = pos; i < n_open && i + 1 < SLOTS; i++)
			open_ids[i] = open_ids[i + 1];
		if (n_open < SLOTS)
			open_ids[n_open] = '0;
	endfunction

	function automatic sdt_pkg::rsp_item_t track_cmd(sdt_pkg::cmd_item_t c);
		sdt_pkg::rsp_item_t r;
		int                 pos;
		r = '0;
		if (!cfg_dir_on) begin
			r.status = sdt_pkg::ST_INVALID_OPCODE;
		end else begin
			case (c.mode)
				sdt_pkg::MODE_WRITE: begin
					if (c.stream_id != '0 && find_open(c.stream_id) < 0) begin
						if (n_open >= cfg_max || n_open >= SLOTS)
							drop_open(0);
						if (n_open < SLOTS) begin
							open_ids[n_open] = c.stream_id;
							n_open++;
						end
					end
				end
				sdt_pkg::MODE_RELEASE_ID: begin
					pos = find_open(c.stream_id);
					if (pos >= 0)
						drop_open(pos);
				end
				sdt_pkg::MODE_ALLOCATE: begin
					if (ns_grant != '0) begin
						r.status = sdt_pkg::ST_INVALID_FIELD;
					end else begin
						r.granted_count = (c.request_count < sys_free) ? c.request_count : sys_free;
						ns_grant = r.granted_count;
						sys_free = sys_free - r.granted_count;
					end
				end
				sdt_pkg::MODE_RELEASE_RES: begin
					ns_grant = '0;
					sys_free = 16'(cfg_max);
				end
				sdt_pkg::MODE_SET_ENABLE: begin
					strm_en = c.enable_bit;
				end
				default: begin
					r.status = sdt_pkg::ST_INVALID_FIELD;
				end
			endcase
		end
		r.open_now    = 5'(n_open);
		r.enabled_now = strm_en;
		return r;
	endfunction

	task automatic add_row(logic [2:0] m, logic [15:0] sid, logic [15:0] req, logic en,
			bit typed, logic [1:0] st = sdt_pkg::ST_SUCCESS, logic [15:0] gr = '0,
			logic [4:0] op = '0, logic en_now = 1'b0);
		dir_row_t row;
		row.c     = '{mode: m, stream_id: sid, request_count: req, enable_bit: en};
		row.typed = typed;
		row.exp   = '{status: st, granted_count: gr, open_now: op, enabled_now: en_now};
		dir_rows.push_back(row);
	endtask

	// drive one transaction; valid is left high so the next one can follow back to back
	task automatic send_cmd(sdt_pkg::cmd_item_t c, bit typed, sdt_pkg::rsp_item_t exp);
		sdt_pkg::rsp_item_t p;
		while ($urandom_range(99) < snd_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		p = track_cmd(c);
		rsp_q.push_back(typed ? exp : p);
		n_cmd++;
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		while (rsp_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write enable is left high; the caller drops it after the last write
	task automatic write_reg(logic [sdt_pkg::CFG_IDX_W-1:0] idx,
			logic [sdt_pkg::CFG_DATA_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		if (idx == sdt_pkg::CFG_MAX_STREAMS)
			cfg_max = d;
		else
			cfg_dir_on = d[0];
	endtask

	function automatic logic [15:0] pick_id();
		if ($urandom_range(99) < 70)
			return id_pool[$urandom_range(23)];
		return 16'($urandom);
	endfunction

	function automatic sdt_pkg::cmd_item_t gen_cmd();
		sdt_pkg::cmd_item_t c;
		int                 k;
		k = $urandom_range(99);
		c.stream_id     = pick_id();
		c.request_count = ($urandom_range(1) != 0) ? 16'($urandom_range(20)) : 16'($urandom);
		c.enable_bit    = 1'($urandom_range(1));
		if (k < 45) begin
			c.mode = sdt_pkg::MODE_WRITE;
		end else if (k < 50) begin
			c.mode      = sdt_pkg::MODE_WRITE;
			c.stream_id = '0;
		end else if (k < 68) begin
			c.mode = sdt_pkg::MODE_RELEASE_ID;
			// mostly hit an open stream so compaction gets exercised
			if (n_open > 0 && $urandom_range(99) < 65)
				c.stream_id = open_ids[$urandom_range(n_open - 1)];
		end else if (k < 80) begin
			c.mode = sdt_pkg::MODE_ALLOCATE;
		end else if (k < 88) begin
			c.mode = sdt_pkg::MODE_RELEASE_RES;
		end else if (k < 95) begin
			c.mode = sdt_pkg::MODE_SET_ENABLE;
		end else begin
			c.mode = 3'($urandom_range(MODE_BAD_HI, MODE_BAD_LO));
		end
		return c;
	endfunction

	initial begin : stim
		logic [4:0]         ph_max [N_PHASES];
		logic               ph_dir [N_PHASES];
		sdt_pkg::rsp_item_t none;

		ph_max = '{5'd8, 5'd1, 5'd16, 5'd0, 5'd31, 5'd5, 5'd12, 5'd2, 5'd16};
		ph_dir = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
		none = '0;

		for (int i = 0; i < SLOTS; i++)
			open_ids[i] = '0;
		n_open     = 0;
		ns_grant   = '0;
		sys_free   = 16'(sdt_pkg::MAX_STREAMS_RESET);
		strm_en    = 1'b0;
		cfg_max    = sdt_pkg::MAX_STREAMS_RESET;
		cfg_dir_on = 1'b1;

		for (int i = 0; i < 20; i++)
			id_pool[i] = 16'(i + 1);
		id_pool[20] = 16'hFFFF;
		id_pool[21] = 16'h8000;
		id_pool[22] = 16'h5555;
		id_pool[23] = 16'hAAAA;

		add_row(sdt_pkg::MODE_WRITE, 16'h0000, 16'h0000, 1'b0, 1,
			sdt_pkg::ST_SUCCESS, 16'd0, 5'd0, 1'b0);
		add_row(sdt_pkg::MODE_SET_ENABLE, 16'h0000, 16'h0000, 1'b1, 1,
			sdt_pkg::ST_SUCCESS, 16'd0, 5'd0, 1'b1);
		add_row(sdt_pkg::MODE_WRITE, 16'hFFFF, 16'h0000, 1'b0, 1,
			sdt_pkg::ST_SUCCESS, 16'd0, 5'd1, 1'b1);
		add_row(sdt_pkg::MODE_WRITE, 16'h0001, 16'h0000, 1'b0, 0);
		add_row(sdt_pkg::MODE_WRITE, 16'h0001, 16'h0000, 1'b0, 0);        // already open
		add_row(sdt_pkg::MODE_RELEASE_ID, 16'h1234, 16'h0000, 1'b0, 0);   // not open
		add_row(sdt_pkg::MODE_RELEASE_ID, 16'hFFFF, 16'h0000, 1'b0, 0);
		add_row(sdt_pkg::MODE_ALLOCATE, 16'h0000, 16'hFFFF, 1'b0, 1,
			sdt_pkg::ST_SUCCESS, 16'd8, 5'd1, 1'b1);
		add_row(sdt_pkg::MODE_ALLOCATE, 16'h0000, 16'h0001, 1'b0, 1,
			sdt_pkg::ST_INVALID_FIELD, 16'd0, 5'd1, 1'b1);
		add_row(sdt_pkg::MODE_RELEASE_RES, 16'h0000, 16'h0000, 1'b0, 0);
		add_row(sdt_pkg::MODE_ALLOCATE, 16'h0000, 16'h0000, 1'b0, 0);     // zero grant
		add_row(sdt_pkg::MODE_ALLOCATE, 16'h0000, 16'h0003, 1'b0, 0);
		add_row(sdt_pkg::MODE_RELEASE_RES, 16'h0000, 16'h0000, 1'b0, 0);
		add_row(MODE_BAD_LO, 16'h0000, 16'h0000, 1'b0, 1,
			sdt_pkg::ST_INVALID_FIELD, 16'd0, 5'd1, 1'b1);
		add_row(MODE_BAD_HI, 16'hFFFF, 16'hFFFF, 1'b1, 1,
			sdt_pkg::ST_INVALID_FIELD, 16'd0, 5'd1, 1'b1);
		add_row(sdt_pkg::MODE_SET_ENABLE, 16'h0000, 16'h0000, 1'b0, 0);
		add_row(sdt_pkg::MODE_WRITE, 16'h8000, 16'h0000, 1'b0, 0);
		for (int i = 2; i <= 8; i++)
			add_row(sdt_pkg::MODE_WRITE, 16'(i), 16'h0000, 1'b0, 0);  // fills, then evicts oldest
		add_row(sdt_pkg::MODE_RELEASE_ID, 16'h0004, 16'h0000, 1'b0, 0); // remove from the middle

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph * 3 / N_PHASES)
				0:       begin snd_pct = 17; rcv_pct = 50; end
				1:       begin snd_pct = 50; rcv_pct = 17; end
				default: begin snd_pct = 0;  rcv_pct = 0;  end
			endcase
			if (ph == 0) begin
				foreach (dir_rows[i])
					send_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].exp);
			end else begin
				wait_drained();
				write_reg(sdt_pkg::CFG_MAX_STREAMS, ph_max[ph]);
				write_reg(sdt_pkg::CFG_DIR_SUPPORTED, sdt_pkg::CFG_DATA_W'(ph_dir[ph]));
				cfg_we <= 1'b0;
			end
			if (ph == 4)
				hold_req++;
			for (int n = 0; n < RAND_PER_PH; n++)
				send_cmd(gen_cmd(), 0, none);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d commands across %0d register settings, incl. full-list eviction,",
			n_cmd, N_PHASES);
		$display("unsupported directives and a long output hold-off; %0d responses, %0d errors",
			n_rsp, errors);
		if (errors == 0 && rsp_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
